// ===== rtl/core/dq_pkg.sv =====
package dq_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 7;

  localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic {
    BACK_IDLE = 1'b0,
    BACK_READ = 1'b1
  } back_state_e;

  // decoded command handed from front to back
  typedef struct packed {
    op_e               op;
    logic              at_tail;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

// ===== rtl/core/dq_ram.sv =====
module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dq_front.sv =====
module dq_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic                        at_tail_i,
  input  logic signed [31:0]          push_value_i,
  output logic                        cmd_valid_o,
  output dq_pkg::cmd_t                cmd_o,
  input  logic                        cmd_pop_i
);
  import dq_pkg::*;

  // two-beat command queue between input port and engine
  cmd_t       entries_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.op      = (operation_i == 1'b1) ? OP_POP : OP_PUSH;
    cmd_in.at_tail = at_tail_i;
    // value only matters for pushes
    cmd_in.value   = (operation_i == 1'b1) ? '0 : push_value_i;
  end

  assign in_stall_o  = (fill_q == 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = entries_q[rd_ptr_q];

  assign push = in_valid_i && !in_stall_o;
  assign pop  = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== rtl/core/dq_back.sv =====
module dq_back #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  input  dq_pkg::cmd_t         cmd_i,
  output logic                 cmd_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [31:0]   pop_value_o,
  output logic [1:0]           status_o,
  output logic [6:0]           entry_count_o,
  output logic                 is_empty_o
);
  import dq_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = PTR_W + 1;

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(DEPTH);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  back_state_e state_q, state_d;

  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q, out_value_d;
  status_e           out_status_q, out_status_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;

  logic              out_free;
  logic              issue;
  logic              is_full;
  logic              is_empty;
  logic [PTR_W-1:0]  head_dec;
  logic [PTR_W-1:0]  head_inc;
  logic [CNT_W-1:0]  offset;
  logic [SUM_W-1:0]  slot_sum;
  logic [PTR_W-1:0]  tail_slot;

  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic              ram_re;
  logic [PTR_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic [CNT_W+6:0]  count_wide;

  assign out_free = !out_valid_q || !out_stall_i;
  assign issue    = (state_q == BACK_IDLE) && cmd_valid_i && out_free;
  assign is_full  = (count_q == FULL_CNT);
  assign is_empty = (count_q == '0);

  assign head_dec = (head_q == '0) ? LAST_SLOT : head_q - PTR_W'(1);
  assign head_inc = (head_q == LAST_SLOT) ? '0 : head_q + PTR_W'(1);

  // tail push lands at head+count, tail pop reads head+count-1
  assign offset    = (cmd_i.op == OP_PUSH) ? count_q : count_q - CNT_W'(1);
  assign slot_sum  = SUM_W'(head_q) + SUM_W'(offset);
  assign tail_slot = (slot_sum >= DEPTH_S) ? PTR_W'(slot_sum - DEPTH_S)
                                           : PTR_W'(slot_sum);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BACK_IDLE: begin
        if (issue && (cmd_i.op == OP_POP) && !is_empty) begin
          state_d = BACK_READ;
        end
      end
      BACK_READ: begin
        if (out_free) begin
          state_d = BACK_IDLE;
        end
      end
      default: state_d = BACK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_d       = head_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    ram_we       = 1'b0;
    ram_waddr    = tail_slot;
    ram_re       = 1'b0;
    ram_raddr    = tail_slot;
    cmd_pop_o    = 1'b0;
    case (state_q)
      BACK_IDLE: begin
        if (issue) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == OP_PUSH) begin
            out_valid_d = 1'b1;
            out_value_d = '0;
            if (is_full) begin
              out_status_d = ST_OVERFLOW;
              out_count_d  = count_q;
            end else begin
              ram_we       = 1'b1;
              ram_waddr    = cmd_i.at_tail ? tail_slot : head_dec;
              head_d       = cmd_i.at_tail ? head_q : head_dec;
              count_d      = count_q + CNT_W'(1);
              out_status_d = ST_DONE;
              out_count_d  = count_q + CNT_W'(1);
            end
          end else if (is_empty) begin
            out_valid_d  = 1'b1;
            out_value_d  = INT_MIN;
            out_status_d = ST_UNDERFLOW;
            out_count_d  = count_q;
          end else begin
            ram_re       = 1'b1;
            ram_raddr    = cmd_i.at_tail ? tail_slot : head_q;
            head_d       = cmd_i.at_tail ? head_q : head_inc;
            count_d      = count_q - CNT_W'(1);
            out_status_d = ST_DONE;
            out_count_d  = count_q - CNT_W'(1);
          end
        end
      end
      BACK_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = ram_rdata;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BACK_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  dq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign count_wide    = {7'd0, out_count_q};
  assign out_valid_o   = out_valid_q;
  assign pop_value_o   = out_value_q;
  assign status_o      = out_status_q;
  assign entry_count_o = count_wide[6:0];
  assign is_empty_o    = (out_count_q == '0);

endmodule

// ===== rtl/core/double_ended_int_queue_top.sv =====
// Double-ended queue of signed 32-bit integers in a ring buffer of DEPTH
// entries. Each input beat pushes or pops at the head or the tail end and
// gives exactly one output beat: the popped value (zero on a push), a status
// (done, pop on empty with the most negative value returned, or push on full
// dropped), the entry count afterwards (low 7 bits) and an empty flag. A
// two-beat command queue decouples the input port from the engine. The
// engine answers a push or a failed pop from the IDLE state and a
// successful pop from the READ state, since the entry RAM has a registered
// read port; a stalled output beat holds the engine, while the command
// queue keeps taking up to two beats. The RAM needs no clearing after reset.
module double_ended_int_queue_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic               at_tail_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pop_value_o,
  output logic [1:0]         status_o,
  output logic [6:0]         entry_count_o,
  output logic               is_empty_o
);
  import dq_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  dq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .at_tail_i    (at_tail_i),
    .push_value_i (push_value_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  dq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pop_value_o   (pop_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o)
  );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import dq_pkg::*;

  localparam int unsigned QDEPTH = 64;

  typedef struct {
    logic signed [31:0] pop_value;
    status_e            status;
    logic [6:0]         entry_count;
    logic               is_empty;
  } deque_result_t;

  class deque_scoreboard;
    logic signed [31:0] slots [QDEPTH];
    int unsigned        head;
    int unsigned        held;
    deque_result_t      awaited[$];
    int unsigned        mismatches;

    function new();
      head = 0;
      held = 0;
      mismatches = 0;
    endfunction

    // predict the output beat caused by one accepted input beat
    function void note_beat(op_e op, logic at_tail, logic signed [31:0] value);
      deque_result_t r;
      r.pop_value = '0;
      r.status    = ST_DONE;
      if (op == OP_PUSH) begin
        if (held >= QDEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          if (at_tail) begin
            slots[(head + held) % QDEPTH] = value;
          end else begin
            head = (head + QDEPTH - 1) % QDEPTH;
            slots[head] = value;
          end
          held++;
        end
      end else begin
        if (held == 0) begin
          r.pop_value = INT_MIN;
          r.status    = ST_UNDERFLOW;
        end else begin
          if (at_tail) begin
            r.pop_value = slots[(head + held - 1) % QDEPTH];
          end else begin
            r.pop_value = slots[head];
            head = (head + 1) % QDEPTH;
          end
          held--;
        end
      end
      r.entry_count = 7'(held);
      r.is_empty    = (held == 0);
      awaited.push_back(r);
    endfunction

    function void check_beat(logic signed [31:0] pop_value, logic [1:0] status,
                             logic [6:0] entry_count, logic is_empty);
      deque_result_t r;
      if (awaited.size() == 0) begin
        $error("output beat with nothing outstanding");
        mismatches++;
        return;
      end
      r = awaited.pop_front();
      if (pop_value !== r.pop_value) begin
        $error("pop_value: expected %0d, actual %0d", r.pop_value, pop_value);
        mismatches++;
      end
      if (status !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, status);
        mismatches++;
      end
      if (entry_count !== r.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", r.entry_count, entry_count);
        mismatches++;
      end
      if (is_empty !== r.is_empty) begin
        $error("is_empty: expected %0d, actual %0d", r.is_empty, is_empty);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               operation_i = OP_PUSH;
  logic               at_tail_i = 1'b0;
  logic signed [31:0] push_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] pop_value_o;
  logic [1:0]         status_o;
  logic [6:0]         entry_count_o;
  logic               is_empty_o;

  bit                 calm = 1'b0;
  deque_scoreboard    sb = new();

  double_ended_int_queue_top #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .at_tail_i    (at_tail_i),
    .push_value_i (push_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pop_value_o  (pop_value_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 32);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_beat(pop_value_o, status_o, entry_count_o, is_empty_o);
    end
  end

  // one beat: optional idle cycles, then hold it until taken
  task automatic send_beat(op_e op, logic at_tail, logic signed [31:0] value);
    while (!calm && $urandom_range(0, 99) < 32) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    at_tail_i    <= at_tail;
    push_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(op, at_tail, value);
  endtask

  task automatic wait_drained();
    while (sb.awaited.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return INT_MIN;
      1: return 32'sh7FFF_FFFF;
      2: return $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
      3: return $signed($urandom_range(0, 255)) - 32'sd128;
      default: return $signed($urandom());
    endcase
  endfunction

  initial begin
    int unsigned push_pct;
    op_e         op;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // underflow at both ends, extremes, ordering from both ends
    send_beat(OP_POP,  1'b0, 32'sd0);
    send_beat(OP_POP,  1'b1, -32'sd1);
    send_beat(OP_PUSH, 1'b0, INT_MIN);
    send_beat(OP_POP,  1'b1, 32'sd0);
    send_beat(OP_PUSH, 1'b1, 32'sh7FFF_FFFF);
    send_beat(OP_POP,  1'b0, 32'sd0);
    send_beat(OP_PUSH, 1'b0, 32'sd1);
    send_beat(OP_PUSH, 1'b0, 32'sd2);
    send_beat(OP_PUSH, 1'b1, 32'sd3);
    send_beat(OP_PUSH, 1'b1, -32'sd1);
    send_beat(OP_POP,  1'b0, 32'sd0);
    send_beat(OP_POP,  1'b1, 32'sd0);
    send_beat(OP_POP,  1'b0, 32'sd0);
    send_beat(OP_POP,  1'b0, 32'sd0);
    send_beat(OP_POP,  1'b0, 32'sd0);
    send_beat(OP_PUSH, 1'b1, 32'sd0);
    send_beat(OP_PUSH, 1'b0, 32'sh5555_5555);
    send_beat(OP_PUSH, 1'b1, $signed(32'hAAAA_AAAA));
    send_beat(OP_POP,  1'b1, 32'sd0);
    send_beat(OP_POP,  1'b1, 32'sd0);
    send_beat(OP_POP,  1'b1, 32'sd0);

    // rotate fill / mixed / drain phases so full and empty are both hit often
    for (int i = 0; i < 900; i++) begin
      case ((i / 120) % 3)
        0: push_pct = 85;
        1: push_pct = 50;
        default: push_pct = 15;
      endcase
      calm = (i >= 400 && i < 550);
      if (i == 300) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        wait_drained();
      end
      op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      send_beat(op, 1'($urandom_range(0, 1)), pick_value());
    end
    calm = 1'b0;

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("[double_ended_int_queue_top] OK");
    end else begin
      $display("[double_ended_int_queue_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[double_ended_int_queue_top] ERROR");
    $finish;
  end

endmodule

// ===== double_ended_int_queue_top.f =====
rtl/core/dq_pkg.sv
rtl/core/dq_ram.sv
rtl/core/dq_front.sv
rtl/core/dq_back.sv
rtl/core/double_ended_int_queue_top.sv
tb/tb_top.sv
